### rtl/core/etm_pkg.sv
// Shared types, constants and microcode for the Euler transform matrix block.
package etm_pkg;

  localparam int ENT_W        = 33;   // Q2.30 entry width, signed
  localparam int CORDIC_STEPS = 30;
  localparam int UC_STEPS     = 32;
  localparam int ACC_W        = 96;
  localparam int PROD_W       = 2 * ENT_W;

  localparam logic signed [ENT_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [ACC_W-1:0] HALF30      = 96'sd536870912;

  typedef enum logic [2:0] {
    CMD_SET_POS   = 3'd0,
    CMD_SET_ANG   = 3'd1,
    CMD_SET_SCL   = 3'd2,
    CMD_ADD_POS   = 3'd3,
    CMD_ADD_ANG   = 3'd4,
    CMD_ADD_SCL   = 3'd5,
    CMD_COMPUTE   = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_MULT,
    ST_EMIT
  } state_t;

  // operand A bank: lane outputs, partial products and rotation entries
  typedef enum logic [3:0] {
    A_CX, A_SX, A_CY, A_SXSY, A_CXSY,
    A_R00, A_R01, A_R02, A_R10, A_R11, A_R12, A_R20, A_R21, A_R22
  } a_sel_t;

  typedef enum logic [2:0] {
    B_SY, B_CZ, B_SZ, B_CY, B_SC_HI, B_SC_LO
  } b_sel_t;

  typedef struct packed {
    a_sel_t     a;
    b_sel_t     b;
    logic       clr;
    logic       neg;
    logic       sh24;
    logic       fin;
    logic       to_res;
    a_sel_t     dst;
    logic [3:0] slot;
    logic [1:0] col;
  } uc_t;

  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Multiply-accumulate program: rotation products first, then the
  // scale products as a high and a low half per entry, row by row.
  function automatic uc_t uc_word(input logic [4:0] k);
    uc_t        u;
    logic [4:0] j;
    logic [3:0] e;
    u = '0;
    j = k - 5'd14;
    e = 4'(j >> 1);
    case (k)
      5'd0:  begin u.a = A_SX;   u.b = B_SY; u.clr = 1'b1; u.fin = 1'b1; u.dst = A_SXSY; end
      5'd1:  begin u.a = A_CX;   u.b = B_SY; u.clr = 1'b1; u.fin = 1'b1; u.dst = A_CXSY; end
      5'd2:  begin u.a = A_CY;   u.b = B_CZ; u.clr = 1'b1; u.fin = 1'b1; u.dst = A_R00; end
      5'd3:  begin
        u.a = A_CY; u.b = B_SZ; u.clr = 1'b1; u.neg = 1'b1; u.fin = 1'b1; u.dst = A_R01;
      end
      5'd4:  begin
        u.a = A_SX; u.b = B_CY; u.clr = 1'b1; u.neg = 1'b1; u.fin = 1'b1; u.dst = A_R12;
      end
      5'd5:  begin u.a = A_CX;   u.b = B_CY; u.clr = 1'b1; u.fin = 1'b1; u.dst = A_R22; end
      5'd6:  begin u.a = A_SXSY; u.b = B_CZ; u.clr = 1'b1; end
      5'd7:  begin u.a = A_CX;   u.b = B_SZ; u.fin = 1'b1; u.dst = A_R10; end
      5'd8:  begin u.a = A_CX;   u.b = B_CZ; u.clr = 1'b1; end
      5'd9:  begin u.a = A_SXSY; u.b = B_SZ; u.neg = 1'b1; u.fin = 1'b1; u.dst = A_R11; end
      5'd10: begin u.a = A_SX;   u.b = B_SZ; u.clr = 1'b1; end
      5'd11: begin u.a = A_CXSY; u.b = B_CZ; u.neg = 1'b1; u.fin = 1'b1; u.dst = A_R20; end
      5'd12: begin u.a = A_CXSY; u.b = B_SZ; u.clr = 1'b1; end
      5'd13: begin u.a = A_SX;   u.b = B_CZ; u.fin = 1'b1; u.dst = A_R21; end
      default: begin
        u.a      = a_sel_t'(4'(A_R00) + e);
        u.b      = j[0] ? B_SC_LO : B_SC_HI;
        u.clr    = ~j[0];
        u.sh24   = ~j[0];
        u.fin    = j[0];
        u.to_res = 1'b1;
        u.slot   = e;
        case (e)
          4'd0, 4'd3, 4'd6: u.col = 2'd0;
          4'd1, 4'd4, 4'd7: u.col = 2'd1;
          default:          u.col = 2'd2;
        endcase
      end
    endcase
    return u;
  endfunction

endpackage

### rtl/core/etm_cordic.sv
// Iterative CORDIC lane: cosine and sine of one binary angle in Q2.30.
module etm_cordic #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [ANGLE_WIDTH-1:0]                 angle_in,
  output logic                                   done,
  output logic signed [etm_pkg::ENT_W-1:0]       cos_o,
  output logic signed [etm_pkg::ENT_W-1:0]       sin_o
);

  localparam int EW = etm_pkg::ENT_W;

  logic signed [EW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [31:0]   z_r, z_nxt, at;
  logic [1:0]           q_r;
  logic [4:0]           i_r;
  logic                 run_r, done_r;
  logic [31:0]          t;
  logic signed [EW-1:0] cos_r, sin_r;

  assign t  = 32'(angle_in) << (32 - ANGLE_WIDTH);
  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = $signed({2'b00, etm_pkg::atan_turn(i_r)});

  always_comb begin
    if (!z_r[31]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        i_r   <= '0;
      end else if (run_r) begin
        if (i_r == 5'(etm_pkg::CORDIC_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        i_r <= i_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= etm_pkg::CORDIC_GAIN;
      y_r <= '0;
      z_r <= $signed({2'b00, t[29:0]});
      q_r <= t[31:30];
    end else if (run_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
    // fold the quadrant back in on the last iteration
    if (run_r && i_r == 5'(etm_pkg::CORDIC_STEPS - 1)) begin
      case (q_r)
        2'd0:    begin cos_r <= x_nxt;  sin_r <= y_nxt;  end
        2'd1:    begin cos_r <= -y_nxt; sin_r <= x_nxt;  end
        2'd2:    begin cos_r <= -x_nxt; sin_r <= -y_nxt; end
        default: begin cos_r <= y_nxt;  sin_r <= -x_nxt; end
      endcase
    end
  end

  assign done  = done_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

### rtl/core/etm_merge.sv
// Merge stage: one shared multiply-accumulate combines lane results into scaled rows.
module etm_merge #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [etm_pkg::ENT_W-1:0]    cos_in [3],
  input  logic signed [etm_pkg::ENT_W-1:0]    sin_in [3],
  input  logic signed [COORD_WIDTH-1:0]       scale_in [3],
  input  logic                                shift_rows,
  output logic                                done,
  output logic signed [COORD_WIDTH-1:0]       res0,
  output logic signed [COORD_WIDTH-1:0]       res1,
  output logic signed [COORD_WIDTH-1:0]       res2
);

  localparam int EW   = etm_pkg::ENT_W;
  localparam int AW   = etm_pkg::ACC_W;
  localparam int PW   = etm_pkg::PROD_W;
  localparam int SE_W = (COORD_WIDTH > 25) ? COORD_WIDTH : 25;
  localparam logic signed [AW-1:0] SAT_MAX = (AW'(1) << (COORD_WIDTH - 1)) - AW'(1);
  localparam logic signed [AW-1:0] SAT_MIN = -SAT_MAX - AW'(1);

  logic signed [EW-1:0] a_bank_r [14];
  logic signed [EW-1:0] b_sy_r, b_cz_r, b_sz_r, b_cy_r;
  logic signed [COORD_WIDTH-1:0] sres_r [9];

  logic [4:0]           step_r;
  logic                 run_r, pv_r, last_r;
  etm_pkg::uc_t         uc_cur, ctl_r;
  logic signed [EW-1:0] a_op, b_op;
  logic signed [SE_W-1:0] s_ext;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r, acc_nxt, pext, term, base, q;
  logic signed [COORD_WIDTH-1:0] sat_v;

  assign uc_cur = etm_pkg::uc_word(step_r);
  assign a_op   = a_bank_r[uc_cur.a];
  assign s_ext  = SE_W'(scale_in[uc_cur.col]);

  always_comb begin
    case (uc_cur.b)
      etm_pkg::B_SY:    b_op = b_sy_r;
      etm_pkg::B_CZ:    b_op = b_cz_r;
      etm_pkg::B_SZ:    b_op = b_sz_r;
      etm_pkg::B_CY:    b_op = b_cy_r;
      etm_pkg::B_SC_HI: b_op = EW'(s_ext >>> 24);
      default:          b_op = $signed(EW'({1'b0, s_ext[23:0]}));
    endcase
  end

  always_comb begin
    pext    = ctl_r.sh24 ? (AW'(prod_r) <<< 24) : AW'(prod_r);
    term    = ctl_r.neg ? -pext : pext;
    base    = ctl_r.clr ? etm_pkg::HALF30 : acc_r;
    acc_nxt = base + term;
    q       = acc_nxt >>> 30;
    if (q > SAT_MAX)      sat_v = COORD_WIDTH'(SAT_MAX);
    else if (q < SAT_MIN) sat_v = COORD_WIDTH'(SAT_MIN);
    else                  sat_v = COORD_WIDTH'(q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pv_r   <= 1'b0;
      last_r <= 1'b0;
      step_r <= '0;
    end else begin
      pv_r   <= run_r;
      last_r <= run_r && step_r == 5'(etm_pkg::UC_STEPS - 1);
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        if (step_r == 5'(etm_pkg::UC_STEPS - 1)) run_r <= 1'b0;
        step_r <= step_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_bank_r[etm_pkg::A_CX]  <= cos_in[0];
      a_bank_r[etm_pkg::A_SX]  <= sin_in[0];
      a_bank_r[etm_pkg::A_CY]  <= cos_in[1];
      a_bank_r[etm_pkg::A_R02] <= sin_in[1];
      b_sy_r <= sin_in[1];
      b_cy_r <= cos_in[1];
      b_cz_r <= cos_in[2];
      b_sz_r <= sin_in[2];
    end else if (pv_r && ctl_r.fin && !ctl_r.to_res) begin
      a_bank_r[ctl_r.dst] <= EW'(q);
    end
    if (run_r) begin
      prod_r <= a_op * b_op;
      ctl_r  <= uc_cur;
    end
    if (pv_r) acc_r <= acc_nxt;
    if (pv_r && ctl_r.fin && ctl_r.to_res) begin
      sres_r[ctl_r.slot] <= sat_v;
    end else if (shift_rows) begin
      // advance the next row into the output slots
      for (int i = 0; i < 6; i++) sres_r[i] <= sres_r[i + 3];
    end
  end

  assign done = pv_r && last_r;
  assign res0 = sres_r[0];
  assign res1 = sres_r[1];
  assign res2 = sres_r[2];

endmodule

### rtl/core/euler_transform_matrix.sv
// Top level of the Euler transform matrix block: state, command decode and row output.
//
// Holds position, three binary angles and per-axis scale; commands 0..5 set or add
// (saturating, angles wrap). A compute command starts three CORDIC lanes on its
// accepting edge; they iterate through the CORDIC steps and then hand off to the
// merge stage. One shared multiply-accumulate unit works through 32 program steps
// and a drain of its pipeline before the first row beat is offered; the three row
// beats then leave in row order, each held while out_stall is high. The next
// command is taken only after the last row beat has left. The CORDIC iteration
// count and the single multiplier set that wait.
module euler_transform_matrix #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_command,
  input  logic signed [31:0]            in_x_value,
  input  logic signed [31:0]            in_y_value,
  input  logic signed [31:0]            in_z_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_row_index,
  output logic signed [COORD_WIDTH-1:0] out_col0,
  output logic signed [COORD_WIDTH-1:0] out_col1,
  output logic signed [COORD_WIDTH-1:0] out_col2,
  output logic signed [COORD_WIDTH-1:0] out_col3,
  output logic                          out_last_row
);

  localparam int EW = etm_pkg::ENT_W;
  localparam int SW = (COORD_WIDTH > 32) ? COORD_WIDTH + 2 : 34;
  localparam logic signed [SW-1:0] SMAX = (SW'(1) << (COORD_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  function automatic logic signed [COORD_WIDTH-1:0] sat_c(input logic signed [SW-1:0] v);
    logic signed [COORD_WIDTH-1:0] r;
    if (v > SMAX)      r = COORD_WIDTH'(SMAX);
    else if (v < SMIN) r = COORD_WIDTH'(SMIN);
    else               r = COORD_WIDTH'(v);
    return r;
  endfunction

  logic signed [COORD_WIDTH-1:0] pos_r [3], pos_nxt [3];
  logic signed [COORD_WIDTH-1:0] scl_r [3], scl_nxt [3];
  logic [ANGLE_WIDTH-1:0]        ang_r [3], ang_nxt [3];
  logic signed [31:0]            vin [3];

  etm_pkg::state_t state_r, state_nxt;
  logic [1:0]      row_r;
  logic            in_acc, lane_start, merge_start, shift_rows, last_beat;
  logic [2:0]      lane_done;
  logic signed [EW-1:0] cos_w [3], sin_w [3];
  logic            merge_done;

  assign vin[0] = in_x_value;
  assign vin[1] = in_y_value;
  assign vin[2] = in_z_value;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      etm_pkg::ST_IDLE: if (in_valid && in_command == etm_pkg::CMD_COMPUTE)
                          state_nxt = etm_pkg::ST_ROT;
      etm_pkg::ST_ROT:  if (lane_done[0]) state_nxt = etm_pkg::ST_MULT;
      etm_pkg::ST_MULT: if (merge_done) state_nxt = etm_pkg::ST_EMIT;
      etm_pkg::ST_EMIT: if (!out_stall && row_r == 2'd2) state_nxt = etm_pkg::ST_IDLE;
      default:          state_nxt = etm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    lane_start  = 1'b0;
    merge_start = 1'b0;
    shift_rows  = 1'b0;
    case (state_r)
      etm_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        lane_start = in_valid && in_command == etm_pkg::CMD_COMPUTE;
      end
      etm_pkg::ST_ROT:  merge_start = lane_done[0];
      etm_pkg::ST_MULT: ;
      etm_pkg::ST_EMIT: begin
        out_valid  = 1'b1;
        shift_rows = !out_stall;
      end
      default: ;
    endcase
  end

  assign in_acc    = in_valid && !in_stall;
  assign last_beat = shift_rows && row_r == 2'd2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_nxt[i] = pos_r[i];
      scl_nxt[i] = scl_r[i];
      ang_nxt[i] = ang_r[i];
      case (in_command)
        etm_pkg::CMD_SET_POS: pos_nxt[i] = sat_c(SW'(vin[i]));
        etm_pkg::CMD_SET_ANG: ang_nxt[i] = vin[i][ANGLE_WIDTH-1:0];
        etm_pkg::CMD_SET_SCL: scl_nxt[i] = sat_c(SW'(vin[i]));
        etm_pkg::CMD_ADD_POS: pos_nxt[i] = sat_c(SW'(pos_r[i]) + SW'(vin[i]));
        etm_pkg::CMD_ADD_ANG: ang_nxt[i] = ang_r[i] + vin[i][ANGLE_WIDTH-1:0];
        etm_pkg::CMD_ADD_SCL: scl_nxt[i] = sat_c(SW'(scl_r[i]) + SW'(vin[i]));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= etm_pkg::ST_IDLE;
      row_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        ang_r[i] <= '0;
        scl_r[i] <= COORD_WIDTH'(65536);
      end
    end else begin
      state_r <= state_nxt;
      if (merge_done) row_r <= '0;
      else if (shift_rows && !last_beat) row_r <= row_r + 2'd1;
      if (in_acc) begin
        for (int i = 0; i < 3; i++) begin
          pos_r[i] <= pos_nxt[i];
          ang_r[i] <= ang_nxt[i];
          scl_r[i] <= scl_nxt[i];
        end
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    etm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (lane_start),
      .angle_in (ang_r[g]),
      .done     (lane_done[g]),
      .cos_o    (cos_w[g]),
      .sin_o    (sin_w[g])
    );
  end

  etm_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (merge_start),
    .cos_in     (cos_w),
    .sin_in     (sin_w),
    .scale_in   (scl_r),
    .shift_rows (shift_rows),
    .done       (merge_done),
    .res0       (out_col0),
    .res1       (out_col1),
    .res2       (out_col2)
  );

  assign out_row_index = row_r;
  assign out_col3      = pos_r[row_r];
  assign out_last_row  = row_r == 2'd2;

endmodule
